// ----- rtl/mtcc_pkg.sv -----
// ----------------------------------------------------------------------------
// mtcc_pkg
// Shared types, constants and the tag table for the markup translator.
// ----------------------------------------------------------------------------
package mtcc_pkg;

    localparam int LIMIT_MAX_DEF = 1024;
    localparam int LOOKAHEAD_DEF = 12;
    localparam int LIMIT_W       = 11;
    localparam int CONS_W        = 16;
    localparam int PAT_MAX       = 12;
    localparam int TABLE_SIZE    = 40;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    // One job for the back end: up to eight code bytes or a bare end marker.
    typedef struct packed {
        logic [63:0] code;
        logic [3:0]  clen;
        logic        fin;
        logic        trunc;
        logic [15:0] cons;
    } job_t;

    typedef struct packed {
        logic [PAT_MAX*8-1:0] pat;
        logic [3:0]           plen;
        logic [23:0]          code;
        logic [1:0]           clen;
    } tag_t;

    // Pack a pattern string, first character in the low byte.
    function automatic tag_t mk(input string s, input logic [23:0] c, input logic [1:0] n);
        tag_t t;
        t.pat = '0;
        for (int k = 0; k < PAT_MAX; k++)
        begin
            if (k < s.len())
            begin
                t.pat[k*8 +: 8] = s[k];
            end
        end
        t.plen = 4'(s.len());
        t.code = c;
        t.clen = n;
        return t;
    endfunction

    // Tag and entity table; code bytes in the low byte first.
    function automatic tag_t tag_entry(input logic [5:0] i);
        tag_t t;
        t = mk("", 24'h0, 2'd0);
        unique case (i)
            6'd0:  t = mk("<left>",     24'h00311e, 2'd2);
            6'd1:  t = mk("<br>",       24'h00000c, 2'd1);
            6'd2:  t = mk("<blink>",    24'h003107, 2'd2);
            6'd3:  t = mk("</blink>",   24'h003007, 2'd2);
            6'd4:  t = mk("<small>",    24'h00311a, 2'd2);
            6'd5:  t = mk("<normal>",   24'h00331a, 2'd2);
            6'd6:  t = mk("<wide>",     24'h31301d, 2'd3);
            6'd7:  t = mk("</wide>",    24'h30301d, 2'd3);
            6'd8:  t = mk("<dblwide>",  24'h31311d, 2'd3);
            6'd9:  t = mk("</dblwide>", 24'h30311d, 2'd3);
            6'd10: t = mk("<serif>",    24'h31351d, 2'd3);
            6'd11: t = mk("</serif>",   24'h30351d, 2'd3);
            6'd12: t = mk("<shadow>",   24'h31371d, 2'd3);
            6'd13: t = mk("</shadow>",  24'h30371d, 2'd3);
            6'd14: t = mk("&uparrow;",  24'h0000c4, 2'd1);
            6'd15: t = mk("&downarrow;", 24'h0000c5, 2'd1);
            6'd16: t = mk("&leftarrow;", 24'h0000c6, 2'd1);
            6'd17: t = mk("&rightarrow;", 24'h0000c7, 2'd1);
            6'd18: t = mk("&cent;",     24'h00009b, 2'd1);
            6'd19: t = mk("&gbp;",      24'h00009c, 2'd1);
            6'd20: t = mk("&yen;",      24'h00009d, 2'd1);
            6'd21: t = mk("&euro;",     24'h0000c2, 2'd1);
            6'd22: t = mk("&pacman;",   24'h0000c8, 2'd1);
            6'd23: t = mk("&boat;",     24'h0000c9, 2'd1);
            6'd24: t = mk("&ball;",     24'h0000ca, 2'd1);
            6'd25: t = mk("&phone;",    24'h0000cb, 2'd1);
            6'd26: t = mk("&heart;",    24'h0000cc, 2'd1);
            6'd27: t = mk("&car;",      24'h0000cd, 2'd1);
            6'd28: t = mk("&handicap;", 24'h0000ce, 2'd1);
            6'd29: t = mk("&rhino;",    24'h0000cf, 2'd1);
            6'd30: t = mk("&mug;",      24'h0000d0, 2'd1);
            6'd31: t = mk("&satdish;",  24'h0000d1, 2'd1);
            6'd32: t = mk("&copy;",     24'h0000d2, 2'd1);
            6'd33: t = mk("&female;",   24'h0000d3, 2'd1);
            6'd34: t = mk("&male;",     24'h0000d4, 2'd1);
            6'd35: t = mk("&bottle;",   24'h0000d5, 2'd1);
            6'd36: t = mk("&disk;",     24'h0000d6, 2'd1);
            6'd37: t = mk("&printer;",  24'h0000d7, 2'd1);
            6'd38: t = mk("&note;",     24'h0000d8, 2'd1);
            6'd39: t = mk("&infinity;", 24'h0000d9, 2'd1);
            default: t = mk("", 24'h0, 2'd0);
        endcase
        return t;
    endfunction

    // Colour digit '0'..'3' to its code character.
    function automatic logic [7:0] hexmap(input logic [7:0] d);
        logic [7:0] r;
        unique case (d[1:0])
            2'd0: r = "0";
            2'd1: r = "4";
            2'd2: r = "8";
            default: r = "C";
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/markup_tag_to_control_code.sv -----
// ----------------------------------------------------------------------------
// markup_tag_to_control_code
// Translates markup text into sign control bytes.
// ----------------------------------------------------------------------------
// An input item is accepted whenever the front end has no window decision to
// make and no end marker to send. Bytes that belong to an open tag are taken
// one per cycle until the twelve-byte window is full. Every other byte is
// decided before the next item is taken, and full is high until then. Each
// decision (one plain byte or one whole tag) becomes at most one job in a
// two-entry queue. The back end delivers one result byte per cycle while pop
// is high, so a colour tag of ten input bytes yields eight results, and the
// front end stalls only while both queue entries are taken. After an
// end-of-string item the remaining window decisions are made, then the end
// marker is sent. The user must write the limit register through
// cfg_valid/cfg_ready only while the block is idle; the block does not enforce this.
module markup_tag_to_control_code
    import mtcc_pkg::*;
#(
    parameter int LIMIT_MAX = LIMIT_MAX_DEF,
    parameter int LOOKAHEAD = LOOKAHEAD_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         text_byte,
    input  logic               byte_present,
    input  logic               end_of_string,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         code_byte,
    output logic               code_valid,
    output logic               final_result,
    output logic               truncated,
    output logic [15:0]        bytes_consumed,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    logic [LIMIT_W-1:0] limit_reg;
    logic jv, jr;
    job_t jb;

    // Limit register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    mtcc_front #(.LIMIT_MAX(LIMIT_MAX), .LOOKAHEAD(LOOKAHEAD)) u_front (
        .clk, .rst_n, .push, .full, .text_byte, .byte_present, .end_of_string,
        .limit(limit_reg), .job_valid(jv), .job_ready(jr), .job(jb)
    );

    mtcc_back u_back (
        .clk, .rst_n, .job_valid(jv), .job_ready(jr), .job(jb), .empty, .pop,
        .code_byte, .code_valid, .final_result, .truncated, .bytes_consumed
    );

endmodule

// ----- rtl/mtcc_match.sv -----
// ----------------------------------------------------------------------------
// mtcc_match
// Combinational matcher for the tag, colour and speed patterns at the head of
// the lookahead window.
// ----------------------------------------------------------------------------
module mtcc_match
    import mtcc_pkg::*;
#(
    parameter int LOOKAHEAD = LOOKAHEAD_DEF
)
(
    input  logic [LOOKAHEAD*8-1:0]     win,
    input  logic [$clog2(LOOKAHEAD+1)-1:0] fill,
    output logic                       hit,
    output logic [3:0]                 used,
    output logic [63:0]                code,
    output logic [3:0]                 clen
);

    logic [PAT_MAX*8-1:0] w;
    tag_t t;
    logic ok;

    // Entries at or past the fill level read as zero.
    always_comb
    begin
        w = '0;
        for (int k = 0; k < PAT_MAX; k++)
        begin
            if (k < LOOKAHEAD && k < 32'(fill))
            begin
                w[k*8 +: 8] = win[k*8 +: 8];
            end
        end
    end

    function automatic logic cdig(input logic [7:0] d);
        return d >= "0" && d <= "3";
    endfunction

    // Table first, in order, then colour, scolour and speed.
    always_comb
    begin
        hit  = 1'b0;
        used = '0;
        code = '0;
        clen = '0;
        for (int i = TABLE_SIZE - 1; i >= 0; i--)
        begin
            t  = tag_entry(6'(i));
            ok = 1'b1;
            for (int k = 0; k < PAT_MAX; k++)
            begin
                if (k < 32'(t.plen) && w[k*8 +: 8] != t.pat[k*8 +: 8])
                begin
                    ok = 1'b0;
                end
            end
            if (ok)
            begin
                hit  = 1'b1;
                used = t.plen;
                code = {40'd0, t.code};
                clen = {2'd0, t.clen};
            end
        end
        if (!hit)
        begin
            if (w[47:0] == {"roloc", "<"} && cdig(w[55:48]) && cdig(w[63:56])
                && cdig(w[71:64]) && w[79:72] == ">")
            begin
                hit  = 1'b1;
                used = 4'd10;
                clen = 4'd8;
                code = {"0", hexmap(w[71:64]), "0", hexmap(w[63:56]),
                        "0", hexmap(w[55:48]), "Z", 8'h1c};
            end
            else if (w[55:0] == {"roloc", "s<"} && cdig(w[63:56])
                && cdig(w[71:64]) && cdig(w[79:72]) && w[87:80] == ">")
            begin
                hit  = 1'b1;
                used = 4'd11;
                clen = 4'd8;
                code = {"0", hexmap(w[79:72]), "0", hexmap(w[71:64]),
                        "0", hexmap(w[63:56]), "Y", 8'h1c};
            end
            else if (w[47:0] == {"deeps", "<"} && w[63:56] == ">"
                && w[55:48] >= "1" && w[55:48] <= "6")
            begin
                hit  = 1'b1;
                used = 4'd8;
                clen = 4'd1;
                code = (w[55:48] == "6") ? 64'h09 : {56'd0, w[55:48] - 8'h1c};
            end
        end
    end

endmodule

// ----- rtl/mtcc_front.sv -----
// ----------------------------------------------------------------------------
// mtcc_front
// Front end: buffers bytes in the lookahead window, classifies the head and
// turns each decision into at most one job for the back end.
// ----------------------------------------------------------------------------
module mtcc_front
    import mtcc_pkg::*;
#(
    parameter int LIMIT_MAX = LIMIT_MAX_DEF,
    parameter int LOOKAHEAD = LOOKAHEAD_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         text_byte,
    input  logic               byte_present,
    input  logic               end_of_string,
    input  logic [LIMIT_W-1:0] limit,
    output logic               job_valid,
    input  logic               job_ready,
    output job_t               job
);

    localparam int FW = $clog2(LOOKAHEAD + 1);
    localparam int OW = $clog2(LIMIT_MAX + 9);

    logic [7:0]     win_reg [LOOKAHEAD];
    logic [7:0]     win_next [LOOKAHEAD];
    logic [FW-1:0]  fill_reg, fill_next;
    logic [OW-1:0]  ocnt_reg, ocnt_next;
    logic [CONS_W-1:0] cons_reg, cons_next;
    logic           stop_reg, stop_next;
    logic           endp_reg, endp_next;   // end marker waiting to be sent
    logic           busy;
    logic [LOOKAHEAD*8-1:0] wflat;
    logic           m_hit;
    logic [3:0]     m_used, m_clen;
    logic [63:0]    m_code;
    logic [OW-1:0]  lim;
    logic           head_tag, decide, acc;
    logic [3:0]     shift_n;
    logic [4:0]     add_n;
    logic [CONS_W:0] cons_sum;

    // Effective limit, clamped to the build maximum.
    assign lim = (32'(limit) > LIMIT_MAX) ? OW'(LIMIT_MAX) : OW'(limit);

    always_comb
    begin
        for (int k = 0; k < LOOKAHEAD; k++)
        begin
            wflat[k*8 +: 8] = win_reg[k];
        end
    end

    mtcc_match #(.LOOKAHEAD(LOOKAHEAD)) u_match (
        .win  (wflat),
        .fill (fill_reg),
        .hit  (m_hit),
        .used (m_used),
        .code (m_code),
        .clen (m_clen)
    );

    // The front is busy while the window head can still be decided or the end marker waits.
    assign head_tag = win_reg[0] == "<" || win_reg[0] == "&";
    assign decide   = fill_reg != '0 && !stop_reg
                      && (!head_tag || fill_reg == FW'(LOOKAHEAD) || endp_reg);
    assign busy     = decide || endp_reg;
    assign full     = busy;
    assign acc      = push && !full;

    // One step per cycle, held while the back-end queue is full: decide the head, or send the end marker.
    always_comb
    begin
        for (int k = 0; k < LOOKAHEAD; k++)
        begin
            win_next[k] = win_reg[k];
        end
        fill_next = fill_reg;
        ocnt_next = ocnt_reg;
        cons_next = cons_reg;
        stop_next = stop_reg;
        endp_next = endp_reg;
        job_valid = 1'b0;
        job       = '0;
        shift_n   = '0;
        add_n     = '0;
        if (decide)
        begin
            if (ocnt_reg >= lim)
            begin
                stop_next = 1'b1;
                fill_next = '0;
            end
            else if (head_tag && m_hit)
            begin
                if (ocnt_reg + OW'(m_clen) > lim)
                begin
                    stop_next = 1'b1;
                    fill_next = '0;
                end
                else
                begin
                    job_valid = 1'b1;
                    job.code  = m_code;
                    job.clen  = m_clen;
                    if (job_ready)
                    begin
                        shift_n = m_used;
                        add_n   = {1'b0, m_clen};
                    end
                end
            end
            else
            begin
                job.code = {56'd0, (win_reg[0] == 8'h0a || win_reg[0] == 8'h09)
                            ? 8'h20 : win_reg[0]};
                job.clen = (win_reg[0] < 8'h20 && win_reg[0] != 8'h0a
                            && win_reg[0] != 8'h09) ? 4'd0 : 4'd1;
                job_valid = job.clen != '0;
                if (job_ready || job.clen == '0)
                begin
                    shift_n = 4'd1;
                    add_n   = {1'b0, job.clen};
                end
            end
        end
        else if (endp_reg)
        begin
            job_valid = 1'b1;
            job.fin   = 1'b1;
            job.trunc = stop_reg;
            job.cons  = cons_reg;
            if (job_ready)
            begin
                endp_next = 1'b0;
                fill_next = '0;
                ocnt_next = '0;
                cons_next = '0;
                stop_next = 1'b0;
            end
        end
        // Retire the consumed head bytes.
        if (shift_n != '0)
        begin
            for (int k = 0; k < LOOKAHEAD; k++)
            begin
                win_next[k] = (k + 32'(shift_n) < LOOKAHEAD)
                              ? win_reg[k + 32'(shift_n)] : win_reg[k];
            end
            fill_next = (FW'(shift_n) >= fill_reg) ? '0 : fill_reg - FW'(shift_n);
            ocnt_next = ocnt_reg + OW'(add_n);
            cons_sum  = {1'b0, cons_reg} + (CONS_W+1)'(shift_n);
            cons_next = cons_sum[CONS_W] ? '1 : cons_sum[CONS_W-1:0];
        end
        else
        begin
            cons_sum = '0;
        end
        // Take a new item while idle.
        if (acc)
        begin
            if (byte_present && !stop_reg && fill_reg < FW'(LOOKAHEAD))
            begin
                win_next[fill_reg[$clog2(LOOKAHEAD)-1:0]] = text_byte;
                fill_next = fill_reg + 1'b1;
            end
            endp_next = end_of_string;
        end
    end

    // Window contents carry no reset.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LOOKAHEAD; k++)
        begin
            win_reg[k] <= win_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ocnt_reg <= '0;
            cons_reg <= '0;
            stop_reg <= 1'b0;
            endp_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            ocnt_reg <= ocnt_next;
            cons_reg <= cons_next;
            stop_reg <= stop_next;
            endp_reg <= endp_next;
        end
    end

endmodule

// ----- rtl/mtcc_back.sv -----
// ----------------------------------------------------------------------------
// mtcc_back
// Back end: a two-entry job queue, then serialization of each job into
// result bytes on a queue-style output.
// ----------------------------------------------------------------------------
module mtcc_back
    import mtcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  code_byte,
    output logic        code_valid,
    output logic        final_result,
    output logic        truncated,
    output logic [15:0] bytes_consumed
);

    job_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic [2:0] idx_reg, idx_next;
    job_t       head;
    logic       wr, done;

    assign job_ready = cnt_reg != 2'd2;
    assign wr        = job_valid && job_ready;
    assign head      = q_reg[rp_reg];
    assign empty     = cnt_reg == 2'd0;

    // Present one byte of the head job at a time.
    assign code_byte      = head.fin ? 8'h00 : head.code[idx_reg*8 +: 8];
    assign code_valid     = !head.fin;
    assign final_result   = head.fin;
    assign truncated      = head.fin && head.trunc;
    assign bytes_consumed = head.fin ? head.cons : 16'd0;

    assign done     = pop && !empty && (head.fin || {1'b0, idx_reg} + 4'd1 == head.clen);
    assign idx_next = done ? 3'd0 : (pop && !empty) ? idx_reg + 3'd1 : idx_reg;

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wp_reg] <= job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (done)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, done};
            idx_reg <= idx_next;
        end
    end

endmodule

// ----- rtl/mtcc_checker.sv -----
// ----------------------------------------------------------------------------
// mtcc_checker
// Port-level checks on the translator's result stream.
// ----------------------------------------------------------------------------
module mtcc_checker
    import mtcc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        code_valid,
    input logic        final_result,
    input logic        truncated,
    input logic [15:0] bytes_consumed
);

    // A data result and an end marker are exclusive.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (code_valid != final_result))
        else $error("code_valid and final_result both set or both clear");

    // Status fields are zero on data results.
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && code_valid) |-> (!truncated && bytes_consumed == 16'd0))
        else $error("status set on a data result");

    // A waiting result is not withdrawn.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result withdrawn without transfer");

endmodule

bind markup_tag_to_control_code mtcc_checker u_chk (
    .clk, .rst_n, .empty, .pop, .code_valid, .final_result, .truncated, .bytes_consumed
);

// ----- bench/markup_checker.sv -----
// ----------------------------------------------------------------------------
// markup_checker
// Watches the text, code and limit channels of the markup translator, keeps
// its own model of the translation and compares every code transfer with it.
// ----------------------------------------------------------------------------
module markup_checker
    import mtcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [7:0]         text_byte,
    input  logic               byte_present,
    input  logic               end_of_string,
    input  logic               empty,
    input  logic               pop,
    input  logic [7:0]         code_byte,
    input  logic               code_valid,
    input  logic               final_result,
    input  logic               truncated,
    input  logic [15:0]        bytes_consumed,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data,
    output int                 fail_count,
    output int                 pending_codes,
    output int                 strings_done
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = LOOKAHEAD_DEF;

    typedef struct packed {
        logic [7:0]  code;
        logic        valid;
        logic        fin;
        logic        trunc;
        logic [15:0] cons;
    } code_item_t;

    code_item_t expected_codes[$];

    // Model state of the translator.
    logic [7:0]         win_q[WIN];
    int                 win_len;
    int                 out_cnt;
    int                 cons_cnt;
    bit                 halted;
    logic [LIMIT_W-1:0] limit_reg;

    function automatic int win_byte(input int k);
        return (k < win_len) ? int'(win_q[k]) : 0;
    endfunction

    // True when the window starts with the given text.
    function automatic bit win_starts(input string s);
        for (int k = 0; k < s.len(); k++)
        begin
            if (win_byte(k) != int'(s[k]))
            begin
                return 0;
            end
        end
        return 1;
    endfunction

    function automatic bit is_digit03(input int d);
        return d >= "0" && d <= "3";
    endfunction

    function automatic logic [7:0] colour_char(input int d);
        logic [7:0] m[4] = '{"0", "4", "8", "C"};
        return m[(d - "0") & 3];
    endfunction

    // Matches the window head; returns input bytes used, 0 on no match.
    function automatic int match_tag(output logic [7:0] codes[8], output int ncodes);
        tag_t t;
        string s;
        int off;
        ncodes = 0;
        for (int k = 0; k < 8; k++)
        begin
            codes[k] = 8'h00;
        end
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            t = tag_entry(6'(i));
            s = "";
            for (int k = 0; k < t.plen; k++)
            begin
                s = {s, string'(t.pat[k*8 +: 8])};
            end
            if (win_starts(s))
            begin
                for (int k = 0; k < t.clen; k++)
                begin
                    codes[k] = t.code[k*8 +: 8];
                end
                ncodes = t.clen;
                return t.plen;
            end
        end
        for (int v = 0; v < 2; v++)
        begin
            off = (v == 0) ? 6 : 7;
            if (win_starts(v == 0 ? "<color" : "<scolor") && is_digit03(win_byte(off))
                && is_digit03(win_byte(off + 1)) && is_digit03(win_byte(off + 2))
                && win_byte(off + 3) == ">")
            begin
                codes[0] = 8'h1c;
                codes[1] = (v == 0) ? "Z" : "Y";
                for (int k = 0; k < 3; k++)
                begin
                    codes[2 + 2*k] = colour_char(win_byte(off + k));
                    codes[3 + 2*k] = "0";
                end
                ncodes = 8;
                return off + 4;
            end
        end
        if (win_starts("<speed") && win_byte(7) == ">")
        begin
            if (win_byte(6) >= "1" && win_byte(6) <= "5")
            begin
                codes[0] = 8'(win_byte(6) - "0" + 8'h14);
                ncodes = 1;
                return 8;
            end
            if (win_byte(6) == "6")
            begin
                codes[0] = 8'h09;
                ncodes = 1;
                return 8;
            end
        end
        return 0;
    endfunction

    function automatic void push_code(input logic [7:0] b);
        expected_codes.push_back('{b, 1'b1, 1'b0, 1'b0, 16'h0});
        out_cnt++;
    endfunction

    function automatic void drop_head(input int n);
        for (int k = 0; k + n < win_len; k++)
        begin
            win_q[k] = win_q[k + n];
        end
        win_len = (n >= win_len) ? 0 : win_len - n;
        cons_cnt = (cons_cnt + n > 65535) ? 65535 : cons_cnt + n;
    endfunction

    // Decides window heads as far as the lookahead allows.
    function automatic void translate_window(input bit flush);
        logic [7:0] codes[8];
        int ncodes;
        int used;
        int lim;
        logic [7:0] head;
        lim = (int'(limit_reg) > LIMIT_MAX_DEF) ? LIMIT_MAX_DEF : int'(limit_reg);
        while (win_len > 0 && !halted)
        begin
            head = win_q[0];
            if (head == "<" || head == "&")
            begin
                if (win_len < WIN && !flush)
                begin
                    return;
                end
                if (out_cnt >= lim)
                begin
                    halted = 1;
                    break;
                end
                used = match_tag(codes, ncodes);
                if (used == 0)
                begin
                    push_code(head);
                    drop_head(1);
                end
                else if (out_cnt + ncodes > lim)
                begin
                    halted = 1;
                    break;
                end
                else
                begin
                    for (int k = 0; k < ncodes; k++)
                    begin
                        push_code(codes[k]);
                    end
                    drop_head(used);
                end
            end
            else
            begin
                if (out_cnt >= lim)
                begin
                    halted = 1;
                    break;
                end
                if (head == 8'h0a || head == 8'h09)
                begin
                    push_code(8'h20);
                end
                else if (head >= 8'h20)
                begin
                    push_code(head);
                end
                drop_head(1);
            end
        end
        if (halted)
        begin
            win_len = 0;
        end
    endfunction

    // Predict on each text transfer and limit write; compare each code transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_codes.delete();
            win_len = 0;
            out_cnt = 0;
            cons_cnt = 0;
            halted = 0;
            limit_reg = LIMIT_RESET;
            fail_count <= 0;
            strings_done <= 0;
            pending_codes <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg = cfg_data;
            end
            if (!empty && pop)
            begin
                if (expected_codes.size() == 0)
                begin
                    $error("code transfer with nothing expected: byte %h", code_byte);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    code_item_t e;
                    e = expected_codes.pop_front();
                    if (e.code !== code_byte || e.valid !== code_valid || e.fin !== final_result
                        || e.trunc !== truncated || e.cons !== bytes_consumed)
                    begin
                        if (e.code !== code_byte)
                            $error("code_byte: expected %h, actual %h", e.code, code_byte);
                        if (e.valid !== code_valid)
                            $error("code_valid: expected %b, actual %b", e.valid, code_valid);
                        if (e.fin !== final_result)
                            $error("final_result: expected %b, actual %b", e.fin, final_result);
                        if (e.trunc !== truncated)
                            $error("truncated: expected %b, actual %b", e.trunc, truncated);
                        if (e.cons !== bytes_consumed)
                            $error("bytes_consumed: expected %0d, actual %0d", e.cons,
                                bytes_consumed);
                        fail_count <= fail_count + 1;
                    end
                    if (e.fin)
                    begin
                        strings_done <= strings_done + 1;
                    end
                end
            end
            if (push && !full)
            begin
                if (byte_present && !halted)
                begin
                    if (win_len < WIN)
                    begin
                        win_q[win_len] = text_byte;
                        win_len++;
                    end
                    translate_window(1'b0);
                end
                if (end_of_string)
                begin
                    translate_window(1'b1);
                    expected_codes.push_back('{8'h00, 1'b0, 1'b1, halted, 16'(cons_cnt)});
                    win_len = 0;
                    out_cnt = 0;
                    cons_cnt = 0;
                    halted = 0;
                end
            end
            pending_codes <= expected_codes.size();
        end
    end
endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives markup strings with tags, entities, colours, speeds and control
// bytes into the translator under several output limits, with random gaps
// and stalls; the checker predicts and compares every code transfer.
// ----------------------------------------------------------------------------
module testbench;
    import mtcc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 40;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [7:0]         text_byte;
    logic               byte_present;
    logic               end_of_string;
    logic               empty;
    logic               pop;
    logic [7:0]         code_byte;
    logic               code_valid;
    logic               final_result;
    logic               truncated;
    logic [15:0]        bytes_consumed;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;
    int                 fail_count;
    int                 pending_codes;
    int                 strings_done;

    int  send_gap_pct;
    int  recv_gap_pct;
    bit  recv_hold;
    int  text_sent;
    int  idle_cycles;

    markup_tag_to_control_code i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .text_byte(text_byte),
        .byte_present(byte_present), .end_of_string(end_of_string), .empty(empty),
        .pop(pop), .code_byte(code_byte), .code_valid(code_valid),
        .final_result(final_result), .truncated(truncated),
        .bytes_consumed(bytes_consumed), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    markup_checker i_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .text_byte(text_byte),
        .byte_present(byte_present), .end_of_string(end_of_string), .empty(empty),
        .pop(pop), .code_byte(code_byte), .code_valid(code_valid),
        .final_result(final_result), .truncated(truncated),
        .bytes_consumed(bytes_consumed), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending_codes(pending_codes),
        .strings_done(strings_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random pops, or a long hold-off when asked.
    always @(posedge clk)
    begin
        if (!rst_n || recv_hold)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_gap_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("markup_tag_to_control_code test failed");
            $finish;
        end
    end

    // Offers one item and waits for its transfer; random gaps before it.
    // Push stays high afterwards so that the next item can follow at once.
    task automatic send_item(input logic [7:0] b, input bit present, input bit last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        text_byte <= b;
        byte_present <= present;
        end_of_string <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (present)
            text_sent++;
    endtask

    task automatic send_text(input string s, input bit last);
        for (int k = 0; k < s.len(); k++)
            send_item(s[k], 1'b1, last && (k == s.len() - 1));
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending_codes != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random fragment: mostly tags and entities, some text and noise.
    function automatic string random_fragment();
        tag_t t;
        string s;
        int sel;
        sel = $urandom_range(9);
        s = "";
        case (sel)
            0, 1, 2:
            begin
                t = tag_entry(6'($urandom_range(TABLE_SIZE - 1)));
                for (int k = 0; k < t.plen; k++)
                    s = {s, string'(t.pat[k*8 +: 8])};
                if ($urandom_range(5) == 0)
                    s = s.substr(0, $urandom_range(t.plen - 1));
            end
            3:
                s = $sformatf("<%scolor%c%c%c>", ($urandom_range(1) ? "s" : ""),
                    8'("0" + $urandom_range(4)), 8'("0" + $urandom_range(3)),
                    8'("0" + $urandom_range(3)));
            4:
                s = $sformatf("<speed%c>", 8'("0" + $urandom_range(7)));
            5:
                s = string'(8'($urandom_range(255)));
            6:
                s = string'(8'($urandom_range(31)));
            default:
                s = string'(8'($urandom_range(8'h7e, 8'h20)));
        endcase
        return s;
    endfunction

    // Random strings until the byte budget for the phase is used.
    task automatic random_strings(input int budget);
        string s;
        int stop_at;
        stop_at = text_sent + budget;
        while (text_sent < stop_at)
        begin
            for (int f = $urandom_range(6, 1); f > 0; f--)
            begin
                s = random_fragment();
                send_text(s, 1'b0);
                if ($urandom_range(15) == 0)
                    send_item(8'($urandom), 1'b0, 1'b0);
            end
            if ($urandom_range(3) == 0)
                send_item(8'($urandom), 1'b0, 1'b1);
            else
                send_item(8'($urandom), 1'b1, 1'b1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        text_byte = 8'h00;
        byte_present = 1'b0;
        end_of_string = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        recv_hold = 1'b0;
        send_gap_pct = 0;
        recv_gap_pct = 0;
        text_sent = 0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings at the reset limit.
        send_text("a\n\t<br>&yen;<wide>", 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_text({"<color312>", 8'h00, 8'hff, 8'h80, "<speed6>"}, 1'b1);
        send_text("<speed0><color4>&bogus;<", 1'b1);
        send_item(8'h00, 1'b0, 1'b1);

        // Limit of one: the second byte stops; then a tag that does not fit.
        write_limit(11'd1);
        send_text("xy", 1'b1);
        write_limit(11'd2);
        send_text("<wide>z", 1'b1);

        // Sender mostly busy, receiver mostly stalling.
        send_gap_pct = 14;
        recv_gap_pct = 84;
        write_limit(11'd2047);
        random_strings(55);

        // Long receiver hold-off while items keep coming.
        recv_hold <= 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                recv_hold <= 1'b0;
            end
            send_text("<scolor123>&infinity;<dblwide>long text here", 1'b1);
        join

        // Sender mostly idle, receiver eager; small limits.
        send_gap_pct = 84;
        recv_gap_pct = 14;
        write_limit(11'($urandom_range(20, 3)));
        random_strings(45);
        wait_drained();

        // No idling, limit at the build maximum.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_limit(11'd1024);
        random_strings(55);

        wait_drained();
        $display("Covered %0d text bytes in %0d strings over limits 1 to 2047,",
            text_sent, strings_done);
        $display("with tags, entities, colours, speeds, control bytes and truncation.");
        if (fail_count == 0)
            $display("markup_tag_to_control_code test passed");
        else
            $display("markup_tag_to_control_code test failed");
        $finish;
    end
endmodule
